@@ hdl/omfq_pkg.sv @@
// omfq_pkg: field widths, request kind codes and result status codes
// for the ordered multiset floor query block
// no dependencies
package omfq_pkg;

    localparam int VALUE_W = 32;
    localparam int TAG_W   = 16;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ABSENT = 2'd2;

endpackage

@@ hdl/omfq_ram.sv @@
// omfq_ram: generic single write port, single read port ram with registered read
// no dependencies
module omfq_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/ordered_multiset_floor_query.sv @@
// ordered_multiset_floor_query: bounded multiset of signed values with insert,
// floor query and remove, scanned one slot per cycle
// depends on omfq_pkg and omfq_ram
//
// Usage:
//   Requests enter on in_valid/in_ready with func, operand_value and query_tag.
//   func 0 inserts operand_value, 1 returns the largest stored value not above
//   operand_value, 2 removes one copy of operand_value; func 3 gives an all-zero
//   result. Each request gives exactly one result on out_valid/out_ready.
//   After reset the block clears the store, one slot per cycle, and in_ready
//   stays low during that pass.
//   A request passes through the scan, drain and finish states: the value store
//   has one read port and every slot is read once per request, then the drain
//   state takes the last read and the finish state writes back and loads the
//   result. in_ready is high only between requests, so a new request is not
//   taken before the last one has loaded its result. A result waits in the
//   output register while the receiver stalls; the next request can be accepted
//   and scanned meanwhile, and its result is held back until the output is free.
//   Each stored slot carries its own occupied bit in the value store.
module ordered_multiset_floor_query
    import omfq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [FUNC_W-1:0]         func,
    input  logic signed [VALUE_W-1:0] operand_value,
    input  logic [TAG_W-1:0]          query_tag,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [TAG_W-1:0]          tag_out,
    output logic                      found,
    output logic signed [VALUE_W-1:0] best_value,
    output logic [STAT_W-1:0]         status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam int ENTRY_W = VALUE_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          rd_idx_reg, rd_idx_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic [FUNC_W-1:0]         func_reg, func_next;
    logic signed [VALUE_W-1:0] op_reg, op_next;
    logic [TAG_W-1:0]          tag_reg, tag_next;
    logic                      hit_reg, hit_next;
    logic [IDX_W-1:0]          slot_reg, slot_next;
    logic signed [VALUE_W-1:0] best_reg, best_next;

    logic                      out_valid_reg, out_valid_next;
    logic [TAG_W-1:0]          tag_out_reg, tag_out_next;
    logic                      found_reg, found_next;
    logic signed [VALUE_W-1:0] best_value_reg, best_value_next;
    logic [STAT_W-1:0]         status_reg, status_next;

    logic                      ram_wr_en;
    logic [IDX_W-1:0]          ram_wr_addr;
    logic [ENTRY_W-1:0]        ram_wr_data;
    logic                      ram_rd_en;
    logic [ENTRY_W-1:0]        ram_rd_data;

    logic                      e_vld;
    logic signed [VALUE_W-1:0] e_val;
    logic                      e_le_op;
    logic                      e_eq_op;
    logic                      e_gt_best;
    logic                      out_free;

    omfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // shared compare unit on the slot just read
    assign e_vld     = ram_rd_data[VALUE_W];
    assign e_val     = $signed(ram_rd_data[VALUE_W-1:0]);
    assign e_le_op   = e_val <= op_reg;
    assign e_eq_op   = e_val == op_reg;
    assign e_gt_best = e_val > best_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_idx_next     = rd_idx_reg;
        rd_vld_next     = 1'b0;
        func_next       = func_reg;
        op_next         = op_reg;
        tag_next        = tag_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        best_next       = best_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        tag_out_next    = tag_out_reg;
        found_next      = found_reg;
        best_value_next = best_value_reg;
        status_next     = status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;

        if (rd_vld_reg)
        begin
            unique case (func_reg)
                FUNC_INSERT:
                begin
                    if (!e_vld && !hit_reg)
                    begin
                        hit_next  = 1'b1;
                        slot_next = rd_idx_reg;
                    end
                end
                FUNC_QUERY:
                begin
                    if (e_vld && e_le_op && (!hit_reg || e_gt_best))
                    begin
                        hit_next  = 1'b1;
                        best_next = e_val;
                    end
                end
                FUNC_REMOVE:
                begin
                    if (e_vld && e_eq_op && !hit_reg)
                    begin
                        hit_next  = 1'b1;
                        slot_next = rd_idx_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    op_next    = operand_value;
                    tag_next   = query_tag;
                    hit_next   = 1'b0;
                    slot_next  = '0;
                    best_next  = '0;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ram_rd_en   = 1'b1;
                rd_vld_next = 1'b1;
                rd_idx_next = idx_reg;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    tag_out_next    = (func_reg == FUNC_QUERY) ? tag_reg : '0;
                    found_next      = (func_reg == FUNC_QUERY) && hit_reg;
                    best_value_next = '0;
                    status_next     = STATUS_OK;
                    ram_wr_addr     = slot_reg;
                    unique case (func_reg)
                        FUNC_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_data = {1'b1, op_reg};
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            best_value_next = hit_reg ? best_reg : -32'sd1;
                        end
                        FUNC_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_data = {1'b0, op_reg};
                            end
                            else
                            begin
                                status_next = STATUS_ABSENT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            rd_idx_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            func_reg       <= '0;
            op_reg         <= '0;
            tag_reg        <= '0;
            hit_reg        <= 1'b0;
            slot_reg       <= '0;
            best_reg       <= '0;
            out_valid_reg  <= 1'b0;
            tag_out_reg    <= '0;
            found_reg      <= 1'b0;
            best_value_reg <= '0;
            status_reg     <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rd_idx_reg     <= rd_idx_next;
            rd_vld_reg     <= rd_vld_next;
            func_reg       <= func_next;
            op_reg         <= op_next;
            tag_reg        <= tag_next;
            hit_reg        <= hit_next;
            slot_reg       <= slot_next;
            best_reg       <= best_next;
            out_valid_reg  <= out_valid_next;
            tag_out_reg    <= tag_out_next;
            found_reg      <= found_next;
            best_value_reg <= best_value_next;
            status_reg     <= status_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign tag_out    = tag_out_reg;
    assign found      = found_reg;
    assign best_value = best_value_reg;
    assign status     = status_reg;

    // store is written only by the clearing pass or the write-back cycle
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_FINISH))
        else $error("store written outside clear or write-back");

    // read data is consumed only while a scan is in flight
    a_read_phase: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("read data outside scan");

    // a new result is loaded only from the write-back cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded at write-back");

    // a failed insert or remove never reports a query answer
    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STATUS_OK) |-> (!found_reg && tag_out_reg == '0))
        else $error("failure status with query fields set");

endmodule
